// ===== sv/spc_pkg.sv =====
// shared types, constants and the sort key function of the per-key cap filter
// no dependencies
package spc_pkg;

   localparam int DEFAULT_BATCH = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int CNT_SAT = 16;
   localparam logic [6:0] MAX_RESET = 7'd1;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [CNT_SAT-1:0] SEEN_MAX = 16'hFFFF;
   localparam int REC_W = 256;
   localparam int RSP_W = REC_W + 2 * CNT_SAT;

   typedef struct packed {
      logic signed [31:0] i_value;
      logic signed [31:0] v_value;
      logic signed [31:0] a_value;
      logic signed [31:0] f_value;
      logic [31:0] profile;
      logic [31:0] causal;
      logic [31:0] anchor;
      logic [31:0] tick;
   } record_type;

   typedef struct packed {
      record_type rec;
      logic summary;
      logic [CNT_SAT-1:0] seen;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic logic [REC_W-1:0] sort_key(input record_type r);
      sort_key = {r.tick, r.anchor, r.causal, r.profile,
         r.f_value ^ SIGN_BIT, r.a_value ^ SIGN_BIT,
         r.v_value ^ SIGN_BIT, r.i_value ^ SIGN_BIT};
   endfunction

endpackage

// ===== sv/spc_queue.sv =====
// short queue between the sorting front and the filtering back
// depends on spc_pkg
module spc_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  spc_pkg::entry_type push_data,
   input  logic pop,
   output spc_pkg::entry_type pop_data,
   output spc_pkg::queue_status_type status
);
   import spc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0] fill_ff, fill_in;

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = slots_ff[rd_ff];
   assign status.valid = (fill_ff != '0);
   assign status.full = (fill_ff == (PTR_W+1)'(QUEUE_DEPTH));
endmodule

// ===== sv/spc_sorter.sv =====
// front: accepts requests into an insertion-sorting cell chain, then drains it
// in order into the queue followed by a summary entry; depends on spc_pkg
module spc_sorter #(
   parameter int BATCH = spc_pkg::DEFAULT_BATCH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  spc_pkg::record_type req_rec,
   input  logic req_tlast,
   input  spc_pkg::queue_status_type q_status,
   output logic q_push,
   output spc_pkg::entry_type q_data
);
   import spc_pkg::*;

   localparam int CNT_W = $clog2(BATCH + 1);
   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic state_ff, state_in;
   record_type cells_ff [BATCH];
   record_type cells_in [BATCH];
   logic [CNT_W-1:0] count_ff, count_in, left_ff, left_in;
   logic [CNT_SAT-1:0] seen_ff, seen_in;
   logic [BATCH-1:0] ins;
   logic accept, store, push_rec;
   logic [REC_W-1:0] new_key;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept = req_tvalid && req_tready;
   assign store = accept && (count_ff < CNT_W'(BATCH));
   assign new_key = sort_key(req_rec);
   assign q_push = (state_ff == ST_DRAIN) && !q_status.full;
   assign push_rec = q_push && (left_ff != '0);

   genvar g;
   generate
      for (g = 0; g < BATCH; g++) begin : g_cell
         assign ins[g] = (CNT_W'(g) >= count_ff) || (new_key < sort_key(cells_ff[g]));
         always_comb begin
            cells_in[g] = cells_ff[g];
            if (store && ins[g]) begin
               if (g == 0) begin
                  cells_in[g] = req_rec;
               end else if (!ins[(g == 0) ? 0 : g-1]) begin
                  cells_in[g] = req_rec;
               end else begin
                  cells_in[g] = cells_ff[(g == 0) ? 0 : g-1];
               end
            end else if (push_rec && (g < BATCH - 1)) begin
               cells_in[g] = cells_ff[(g < BATCH - 1) ? g+1 : g];
            end
         end
         always_ff @(posedge clock) begin
            cells_ff[g] <= cells_in[g];
         end
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      seen_in = seen_ff;
      left_in = left_ff;
      q_data.rec = cells_ff[0];
      q_data.summary = 1'b0;
      q_data.seen = '0;
      if (accept) begin
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
         if (store) begin
            count_in = count_ff + 1'b1;
         end
         if (req_tlast) begin
            state_in = ST_DRAIN;
            left_in = count_in;
         end
      end
      if (left_ff == '0) begin
         q_data.rec = '0;
         q_data.summary = 1'b1;
         q_data.seen = seen_ff;
      end
      if (q_push) begin
         if (left_ff != '0) begin
            left_in = left_ff - 1'b1;
         end else begin
            count_in = '0;
            seen_in = '0;
            state_in = ST_LOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         seen_ff <= '0;
         left_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         seen_ff <= seen_in;
         left_ff <= left_in;
      end
   end
endmodule

// ===== sv/spc_filter.sv =====
// back: takes sorted entries from the queue, caps each tick and anchor run,
// and holds the response register; depends on spc_pkg
module spc_filter (
   input  logic clock,
   input  logic reset,
   input  logic [6:0] max_per_anchor,
   input  spc_pkg::queue_status_type q_status,
   input  spc_pkg::entry_type q_data,
   output logic q_pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [spc_pkg::RSP_W-1:0] rsp_tdata,
   output logic rsp_tuser,
   output logic rsp_tlast
);
   import spc_pkg::*;

   logic out_valid_ff, out_valid_in, out_sum_ff, out_sum_in;
   logic [RSP_W-1:0] out_data_ff, out_data_in;
   logic first_ff, first_in;
   logic [31:0] prev_tick_ff, prev_tick_in, prev_anchor_ff, prev_anchor_in;
   logic [6:0] run_ff, run_in, kept_ff, kept_in, run_cur;
   logic can_load, new_run, keep;

   assign can_load = !out_valid_ff || rsp_tready;
   assign q_pop = q_status.valid && can_load;
   assign new_run = first_ff || (q_data.rec.tick != prev_tick_ff)
      || (q_data.rec.anchor != prev_anchor_ff);
   assign run_cur = new_run ? '0 : run_ff;
   assign keep = run_cur < max_per_anchor;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_sum_in = out_sum_ff;
      out_data_in = out_data_ff;
      first_in = first_ff;
      prev_tick_in = prev_tick_ff;
      prev_anchor_in = prev_anchor_ff;
      run_in = run_ff;
      kept_in = kept_ff;
      if (can_load) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         if (q_data.summary) begin
            out_valid_in = 1'b1;
            out_sum_in = 1'b1;
            out_data_in = {q_data.seen - CNT_SAT'(kept_ff), q_data.seen, REC_W'(0)};
            first_in = 1'b1;
            kept_in = '0;
            run_in = '0;
         end else begin
            first_in = 1'b0;
            prev_tick_in = q_data.rec.tick;
            prev_anchor_in = q_data.rec.anchor;
            run_in = run_cur;
            if (keep) begin
               out_valid_in = 1'b1;
               out_sum_in = 1'b0;
               out_data_in = {(2*CNT_SAT)'(0), q_data.rec};
               run_in = run_cur + 1'b1;
               kept_in = kept_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         first_ff <= 1'b1;
         run_ff <= '0;
         kept_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         first_ff <= first_in;
         run_ff <= run_in;
         kept_ff <= kept_in;
      end
      out_sum_ff <= out_sum_in;
      out_data_ff <= out_data_in;
      prev_tick_ff <= prev_tick_in;
      prev_anchor_ff <= prev_anchor_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_sum_ff;
   assign rsp_tlast = out_sum_ff;
endmodule

// ===== sv/sorted_per_key_cap_filter.sv =====
// top level of the sorted per-key cap filter: csr register, sorter, queue, filter
// depends on spc_pkg, spc_sorter, spc_queue, spc_filter
//
// channel   dir  payload
// req_*     in   tdata: tick, anchor, causal, profile, f, a, v, i; tlast: last_in
// rsp_*     out  tdata: record fields, seen_count, dropped_count; tuser: is_summary
// csr_*     in   wr_data: max_per_anchor
//
// one request per cycle while loading, up to BATCH stored; the cell chain inserts
// each record in one compare per cell. after the last request the chain drains one
// entry a cycle while the queue has room; no request is taken until the summary
// is queued. synchronous reset clears all control state; either side may stall freely.
module sorted_per_key_cap_filter #(
   parameter int BATCH = spc_pkg::DEFAULT_BATCH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [spc_pkg::REC_W-1:0] req_tdata, // tick, anchor, causal, profile,
                                                // f_value, a_value, v_value, i_value
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [spc_pkg::RSP_W-1:0] rsp_tdata, // out_tick, out_anchor, out_causal,
                                                // out_profile, out_f, out_a, out_v, out_i,
                                                // seen_count, dropped_count
   output logic rsp_tuser,                      // is_summary
   output logic rsp_tlast,
   input  logic csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import spc_pkg::*;

   logic [6:0] max_ff;
   logic q_push, q_pop;
   entry_type q_in, q_out;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   spc_sorter #(.BATCH(BATCH)) u_sorter (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_rec(record_type'(req_tdata)), .req_tlast,
      .q_status, .q_push, .q_data(q_in)
   );

   spc_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in),
      .pop(q_pop), .pop_data(q_out), .status(q_status)
   );

   spc_filter u_filter (
      .clock, .reset, .max_per_anchor(max_ff), .q_status, .q_data(q_out),
      .q_pop, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("summary flag and last flag disagree");

   a_counts_only_in_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[RSP_W-1:REC_W] == '0))
      else $error("counts set on a kept record");

   a_no_drop_beyond_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[RSP_W-1:REC_W+CNT_SAT] <= rsp_tdata[REC_W+CNT_SAT-1:REC_W]))
      else $error("dropped count exceeds seen count");
endmodule

// ===== sim/sorted_per_key_cap_filter_checker.sv =====
// checker for the sorted per-key cap filter: watches the request, response and csr ports,
// predicts each batch result and compares field by field
// depends on spc_pkg
module sorted_per_key_cap_filter_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [spc_pkg::REC_W-1:0] req_tdata,
   input  logic req_tlast,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [spc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic rsp_tuser,
   input  logic rsp_tlast,
   input  logic csr_wr_en,
   input  logic [6:0] csr_wr_data,
   output int fail_count,
   output int pending_count,
   output int batch_count,
   output int kept_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spc_pkg::*;

   localparam int BATCH = DEFAULT_BATCH;

   typedef struct packed {
      logic [RSP_W-1:0] data;
      logic summary;
      logic last;
   } rsp_beat_type;

   logic [6:0] cap_limit;
   record_type batch_recs[$];
   int unsigned seen_in_batch;
   rsp_beat_type expected_rsps[$];

   function automatic bit rec_less(record_type x, record_type y);
      logic [REC_W-1:0] kx, ky;
      kx = {x.tick, x.anchor, x.causal, x.profile, x.f_value ^ 32'h8000_0000,
         x.a_value ^ 32'h8000_0000, x.v_value ^ 32'h8000_0000, x.i_value ^ 32'h8000_0000};
      ky = {y.tick, y.anchor, y.causal, y.profile, y.f_value ^ 32'h8000_0000,
         y.a_value ^ 32'h8000_0000, y.v_value ^ 32'h8000_0000, y.i_value ^ 32'h8000_0000};
      return kx < ky;
   endfunction

   task automatic predict_batch();
      record_type sorted[$];
      record_type cur;
      int j;
      int unsigned run, drops;
      rsp_beat_type b;
      foreach (batch_recs[i]) begin
         cur = batch_recs[i];
         j = sorted.size();
         sorted.insert(sorted.size(), cur);
         while (j > 0 && rec_less(cur, sorted[j-1])) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = cur;
      end
      run = 0;
      drops = 0;
      foreach (sorted[i]) begin
         if (i == 0 || sorted[i].tick != sorted[i-1].tick
               || sorted[i].anchor != sorted[i-1].anchor)
            run = 0;
         if (run < cap_limit) begin
            b.data = {32'd0, sorted[i]};
            b.summary = 1'b0;
            b.last = 1'b0;
            expected_rsps.insert(expected_rsps.size(), b);
            run++;
         end else begin
            drops++;
         end
      end
      drops += seen_in_batch - sorted.size();
      if (drops > 16'hFFFF) drops = 16'hFFFF;
      b.data = {drops[15:0], seen_in_batch[15:0], {REC_W{1'b0}}};
      b.summary = 1'b1;
      b.last = 1'b1;
      expected_rsps.insert(expected_rsps.size(), b);
      batch_recs.delete();
      seen_in_batch = 0;
   endtask

   always @(posedge clock) begin
      rsp_beat_type e;
      if (reset) begin
         cap_limit <= MAX_RESET;
         batch_recs.delete();
         expected_rsps.delete();
         seen_in_batch = 0;
         fail_count <= 0;
         pending_count <= 0;
         batch_count <= 0;
         kept_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("%0t unexpected response data=%h user=%b", $realtime, rsp_tdata,
                     rsp_tuser);
            end else begin
               e = expected_rsps.pop_front();
               if (e.data !== rsp_tdata || e.summary !== rsp_tuser || e.last !== rsp_tlast) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("%0t mismatch exp data=%h user=%b last=%b",
                        $realtime, e.data, e.summary, e.last,
                        " got data=%h user=%b last=%b", rsp_tdata, rsp_tuser, rsp_tlast);
               end
               if (e.summary) batch_count <= batch_count + 1;
               else kept_count <= kept_count + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            if (seen_in_batch < 16'hFFFF) seen_in_batch++;
            if (batch_recs.size() < BATCH)
               batch_recs.insert(batch_recs.size(), record_type'(req_tdata));
            if (req_tlast) predict_batch();
         end
         if (csr_wr_en) cap_limit <= csr_wr_data;
         pending_count <= expected_rsps.size();
      end
   end
endmodule

// ===== sim/sorted_per_key_cap_filter_tb.sv =====
// testbench top for the sorted per-key cap filter: clock, reset, request stimulus,
// csr phases and verdict; depends on spc_pkg, the block and its checker
module sorted_per_key_cap_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REC_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;
   int fail_count, pending_count, batch_count, kept_count;
   int cycle_count = 0;
   bit steady_phase = 1'b0;
   int sent_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_per_key_cap_filter DUT (.*);

   sorted_per_key_cap_filter_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady_phase || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("** sorted_per_key_cap_filter: FAILED **");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word(int unsigned pool);
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(pool);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(record_type r, logic last);
      while (!steady_phase && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_and_set(logic [6:0] cap);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_batch(int len, int unsigned pool);
      record_type r;
      for (int k = 0; k < len; k++) begin
         r.tick = ($urandom_range(3) == 0) ? pick_word(pool) : $urandom_range(pool);
         r.anchor = ($urandom_range(3) == 0) ? pick_word(pool) : $urandom_range(pool);
         r.causal = ($urandom_range(1) == 0) ? pick_word(pool) : $urandom_range(1);
         r.profile = pick_word(pool);
         r.f_value = pick_word(pool);
         r.a_value = pick_word(pool);
         r.v_value = pick_word(pool);
         r.i_value = pick_word(pool);
         send_request(r, k == len - 1);
      end
   endtask

   initial begin
      record_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: single record, extremes, identical and signed-ordered records
      r = '0;
      send_request(r, 1'b1);
      r = '1;
      send_request(r, 1'b0);
      r = '0;
      r.f_value = 32'sh8000_0000;
      send_request(r, 1'b0);
      r.f_value = 32'sh7FFF_FFFF;
      send_request(r, 1'b0);
      send_request(r, 1'b0);
      r.anchor = 32'd1;
      send_request(r, 1'b0);
      r.tick = 32'hFFFF_FFFF;
      send_request(r, 1'b1);
      drain_and_set(7'd0);
      random_batch(4, 2);
      drain_and_set(7'd64);
      // overflow: more records than the batch holds
      random_batch(DEFAULT_BATCH + 3, 3);
      drain_and_set(7'd127);
      random_batch(6, 1);
      drain_and_set(7'd2);
      steady_phase = 1'b1;
      random_batch(10, 1);
      steady_phase = 1'b0;
      while (sent_count < 115) begin
         if ($urandom_range(5) == 0) drain_and_set(7'($urandom_range(4)));
         random_batch(($urandom_range(7) == 0) ? $urandom_range(20, 34)
            : $urandom_range(1, 8), $urandom_range(1, 3));
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("%0d requests in %0d batches, %0d kept records checked, caps 0 to 127",
         sent_count, batch_count, kept_count);
      if (fail_count == 0) $display("** sorted_per_key_cap_filter: PASSED **");
      else $display("** sorted_per_key_cap_filter: FAILED **");
      $finish;
   end
endmodule
